// ===== hw/rtl/fq_pkg.sv =====
// ----------------------------------------------------------------------------
// fq_pkg
// Shared constants and types of the frame-to-quaternion converter.
// ----------------------------------------------------------------------------
package fq_pkg;

  // Width of every vector and quaternion component
  localparam int DATA_W = 16;

  // Default number of fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 14;

  // Width of a normalized magnitude: the largest lies in [2^29, 2^30)
  localparam int NORM_W = 30;

  // One root bit per square-root stage
  localparam int SQRT_STAGES = NORM_W + 1;

  // Branch of the trace method, named after the dominant component
  typedef enum logic [1:0] {
    BR_W,
    BR_X,
    BR_Y,
    BR_Z
  } fq_branch_t;

endpackage

// ===== hw/rtl/frame_to_quaternion_top.sv =====
// Throughput: one transaction per cycle unless out_ready holds the pipeline; every stage carries its own valid bit.
// The depth is set by the square-root pipeline (one root bit per stage) and the
// per-component divider (one quotient bit per stage).
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// frame_to_quaternion_top
// Builds a rotation frame from forward and up vectors and converts it to a
// normalized quaternion, with an identity result for degenerate frames.
// ----------------------------------------------------------------------------
module frame_to_quaternion_top #(
  parameter int FRAC_BITS = fq_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [fq_pkg::DATA_W-1:0]   in_fwd_x,
  input  logic signed [fq_pkg::DATA_W-1:0]   in_fwd_y,
  input  logic signed [fq_pkg::DATA_W-1:0]   in_fwd_z,
  input  logic signed [fq_pkg::DATA_W-1:0]   in_up_x,
  input  logic signed [fq_pkg::DATA_W-1:0]   in_up_y,
  input  logic signed [fq_pkg::DATA_W-1:0]   in_up_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fq_pkg::DATA_W-1:0]   out_quat_x,
  output logic signed [fq_pkg::DATA_W-1:0]   out_quat_y,
  output logic signed [fq_pkg::DATA_W-1:0]   out_quat_z,
  output logic signed [fq_pkg::DATA_W-1:0]   out_quat_w,
  output logic                               out_degenerate
);

  localparam int F     = FRAC_BITS;
  localparam int DW    = fq_pkg::DATA_W;
  localparam int NW    = fq_pkg::NORM_W;
  localparam int SQS   = fq_pkg::SQRT_STAGES;
  // left vector
  localparam int MPW   = 2 * DW;
  localparam int LW    = 35 - F;
  localparam int RWL   = (F + 2 > MPW + 2) ? F + 2 : MPW + 2;
  // true up vector
  localparam int VPW   = DW + LW;
  localparam int RWV   = (F + 2 > VPW + 2) ? F + 2 : VPW + 2;
  localparam int VW0   = 53 - 2 * F;
  localparam int VW    = (VW0 > 4) ? VW0 : 4;
  // quaternion candidates
  localparam int MW0   = (LW > VW) ? LW : VW;
  localparam int MW1   = (MW0 > DW) ? MW0 : DW;
  localparam int MW    = (MW1 > F + 2) ? MW1 : F + 2;
  localparam int PW    = MW + 3;
  localparam int MSBW  = $clog2(PW);
  // magnitude and division
  localparam int SQW   = 2 * NW + 2;
  localparam int MAGW  = NW + 1;
  localparam int RW    = MAGW + 1;
  localparam int QW    = F + 1;
  localparam int EW    = (QW + 2 > DW + 1) ? QW + 2 : DW + 1;
  // stage numbering
  localparam int ST_MP = 0;
  localparam int ST_L  = 1;
  localparam int ST_VP = 2;
  localparam int ST_V  = 3;
  localparam int ST_TR = 4;
  localparam int ST_SL = 5;
  localparam int ST_LD = 6;
  localparam int ST_SH = 7;
  localparam int ST_SQ = 8;
  localparam int ST_SM = 9;
  localparam int SQ0   = 10;
  localparam int DV0   = SQ0 + SQS;
  localparam int OUTS  = DV0 + QW;
  localparam int NS    = OUTS + 1;

  localparam logic signed [RWL-1:0] HALF_L  = RWL'(1) <<< (F - 1);
  localparam logic signed [RWV-1:0] HALF_V  = RWV'(1) <<< (F - 1);
  localparam logic signed [PW-1:0]  ONE_P   = PW'(1) <<< F;
  localparam logic signed [DW-1:0]  ONE_SAT = (F >= 15) ? DW'(32767) : DW'(1 << F);
  localparam logic signed [EW-1:0]  SAT_HI  = EW'(32767);
  localparam logic signed [EW-1:0]  SAT_LO  = -EW'(32768);
  localparam logic [SQW-1:0]        MAG_MIN = SQW'(1) << (NW - 1);

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when empty or when its successor advances
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld_r, vld_nxt, vin;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vin     = {vld_r[NS-2:0], in_valid};
    vld_nxt = (en[NS-1:0] & vin) | (~en[NS-1:0] & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

  // --------------------------------------------------------------------------
  // Stage: cross products of up x forward
  // --------------------------------------------------------------------------
  logic signed [MPW-1:0] mp_r [6];
  logic signed [DW-1:0]  f0_r [3];

  always_ff @(posedge clk) begin
    if (en[ST_MP]) begin
      mp_r[0] <= in_up_y * in_fwd_z;
      mp_r[1] <= in_up_z * in_fwd_y;
      mp_r[2] <= in_up_z * in_fwd_x;
      mp_r[3] <= in_up_x * in_fwd_z;
      mp_r[4] <= in_up_x * in_fwd_y;
      mp_r[5] <= in_up_y * in_fwd_x;
      f0_r[0] <= in_fwd_x;
      f0_r[1] <= in_fwd_y;
      f0_r[2] <= in_fwd_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: round the left vector, half up
  // --------------------------------------------------------------------------
  logic signed [LW-1:0]  l1_nxt [3];
  logic signed [LW-1:0]  l1_r   [3];
  logic signed [DW-1:0]  f1_r   [3];
  logic signed [RWL-1:0] dl     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dl[i]     = RWL'(mp_r[2*i]) - RWL'(mp_r[2*i+1]) + HALF_L;
      l1_nxt[i] = LW'(dl[i] >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_L]) begin
      l1_r <= l1_nxt;
      f1_r <= f0_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: cross products of forward x left
  // --------------------------------------------------------------------------
  logic signed [VPW-1:0] vp_r [6];
  logic signed [LW-1:0]  l2_r [3];
  logic signed [DW-1:0]  f2_r [3];

  always_ff @(posedge clk) begin
    if (en[ST_VP]) begin
      vp_r[0] <= f1_r[1] * l1_r[2];
      vp_r[1] <= f1_r[2] * l1_r[1];
      vp_r[2] <= f1_r[2] * l1_r[0];
      vp_r[3] <= f1_r[0] * l1_r[2];
      vp_r[4] <= f1_r[0] * l1_r[1];
      vp_r[5] <= f1_r[1] * l1_r[0];
      l2_r    <= l1_r;
      f2_r    <= f1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: round the true up vector, half up
  // --------------------------------------------------------------------------
  logic signed [VW-1:0]  v3_nxt [3];
  logic signed [VW-1:0]  v3_r   [3];
  logic signed [LW-1:0]  l3_r   [3];
  logic signed [DW-1:0]  f3_r   [3];
  logic signed [RWV-1:0] dv     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i]     = RWV'(vp_r[2*i]) - RWV'(vp_r[2*i+1]) + HALF_V;
      v3_nxt[i] = VW'(dv[i] >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_V]) begin
      v3_r <= v3_nxt;
      l3_r <= l2_r;
      f3_r <= f2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: trace, branch choice and all candidate sums
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] lx, ly, lz, vx, vy, vz, fx, fy, fz, tr;
  logic signed [PW-1:0] s4_nxt [4];
  logic signed [PW-1:0] d4_nxt [3];
  logic signed [PW-1:0] e4_nxt [3];
  logic signed [PW-1:0] s4_r   [4];
  logic signed [PW-1:0] d4_r   [3];
  logic signed [PW-1:0] e4_r   [3];
  fq_pkg::fq_branch_t   br_nxt, br_r;

  always_comb begin
    lx = PW'(l3_r[0]);
    ly = PW'(l3_r[1]);
    lz = PW'(l3_r[2]);
    vx = PW'(v3_r[0]);
    vy = PW'(v3_r[1]);
    vz = PW'(v3_r[2]);
    fx = PW'(f3_r[0]);
    fy = PW'(f3_r[1]);
    fz = PW'(f3_r[2]);
    tr = lx + vy + fz;
    s4_nxt[0] = ONE_P + tr;
    s4_nxt[1] = ONE_P + lx - vy - fz;
    s4_nxt[2] = ONE_P + vy - lx - fz;
    s4_nxt[3] = ONE_P + fz - lx - vy;
    d4_nxt[0] = vz - fy;
    d4_nxt[1] = fx - lz;
    d4_nxt[2] = ly - vx;
    e4_nxt[0] = ly + vx;
    e4_nxt[1] = lz + fx;
    e4_nxt[2] = fy + vz;
    if (tr > 0) begin
      br_nxt = fq_pkg::BR_W;
    end else if (lx >= vy && lx >= fz) begin
      br_nxt = fq_pkg::BR_X;
    end else if (vy > fz) begin
      br_nxt = fq_pkg::BR_Y;
    end else begin
      br_nxt = fq_pkg::BR_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_TR]) begin
      s4_r <= s4_nxt;
      d4_r <= d4_nxt;
      e4_r <= e4_nxt;
      br_r <= br_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: select the branch, flag a non-positive root argument, take magnitudes
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] p5    [4];
  logic signed [PW-1:0] s5;
  logic [PW-1:0]        a5_nxt [4];
  logic [PW-1:0]        a5_r   [4];
  logic [3:0]           ng5_nxt, ng5_r;
  logic                 dg5_r;

  always_comb begin
    case (br_r)
      fq_pkg::BR_W: begin
        p5[0] = d4_r[0]; p5[1] = d4_r[1]; p5[2] = d4_r[2]; p5[3] = s4_r[0];
        s5    = s4_r[0];
      end
      fq_pkg::BR_X: begin
        p5[0] = s4_r[1]; p5[1] = e4_r[0]; p5[2] = e4_r[1]; p5[3] = d4_r[0];
        s5    = s4_r[1];
      end
      fq_pkg::BR_Y: begin
        p5[0] = e4_r[0]; p5[1] = s4_r[2]; p5[2] = e4_r[2]; p5[3] = d4_r[1];
        s5    = s4_r[2];
      end
      fq_pkg::BR_Z: begin
        p5[0] = e4_r[1]; p5[1] = e4_r[2]; p5[2] = s4_r[3]; p5[3] = d4_r[2];
        s5    = s4_r[3];
      end
      default: begin
        p5[0] = d4_r[0]; p5[1] = d4_r[1]; p5[2] = d4_r[2]; p5[3] = s4_r[0];
        s5    = s4_r[0];
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      ng5_nxt[i] = p5[i][PW-1];
      a5_nxt[i]  = ng5_nxt[i] ? PW'(-p5[i]) : PW'(p5[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SL]) begin
      a5_r  <= a5_nxt;
      ng5_r <= ng5_nxt;
      dg5_r <= (s5 <= 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage: leading one of the largest magnitude
  // --------------------------------------------------------------------------
  logic [PW-1:0]   orv;
  logic [MSBW-1:0] msb6_nxt, msb6_r;
  logic [PW-1:0]   a6_r [4];
  logic [3:0]      ng6_r;
  logic            dg6_r;

  always_comb begin
    orv      = a5_r[0] | a5_r[1] | a5_r[2] | a5_r[3];
    msb6_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (orv[i]) begin
        msb6_nxt = MSBW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_LD]) begin
      msb6_r <= msb6_nxt;
      a6_r   <= a5_r;
      ng6_r  <= ng5_r;
      dg6_r  <= dg5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: shift all four so the largest lands in [2^29, 2^30)
  // --------------------------------------------------------------------------
  logic [PW+NW-1:0] ext7   [4];
  logic [MSBW:0]    sh7;
  logic [NW-1:0]    a7_nxt [4];
  logic [NW-1:0]    a7_r   [4];
  logic [3:0]       ng7_r;
  logic             dg7_r;

  always_comb begin
    sh7 = (MSBW+1)'(msb6_r) + (MSBW+1)'(1);
    for (int i = 0; i < 4; i++) begin
      ext7[i]   = {a6_r[i], NW'(0)} >> sh7;
      a7_nxt[i] = ext7[i][NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SH]) begin
      a7_r  <= a7_nxt;
      ng7_r <= ng6_r;
      dg7_r <= dg6_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: squares
  // --------------------------------------------------------------------------
  logic [2*NW-1:0] sq8_r [4];
  logic [NW-1:0]   a8_r  [4];
  logic [3:0]      ng8_r;
  logic            dg8_r;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int i = 0; i < 4; i++) begin
        sq8_r[i] <= a7_r[i] * a7_r[i];
      end
      a8_r  <= a7_r;
      ng8_r <= ng7_r;
      dg8_r <= dg7_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: sum of squares
  // --------------------------------------------------------------------------
  logic [SQW-1:0] sum9_r;
  logic [NW-1:0]  a9_r [4];
  logic [3:0]     ng9_r;
  logic           dg9_r;

  always_ff @(posedge clk) begin
    if (en[ST_SM]) begin
      sum9_r <= SQW'(sq8_r[0]) + SQW'(sq8_r[1]) + SQW'(sq8_r[2]) + SQW'(sq8_r[3]);
      a9_r   <= a8_r;
      ng9_r  <= ng8_r;
      dg9_r  <= dg8_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one root bit per stage, floor result
  // --------------------------------------------------------------------------
  logic [SQW-1:0] sq_n_r   [SQS];
  logic [SQW-1:0] sq_res_r [SQS];
  logic [NW-1:0]  sq_a_r   [SQS][4];
  logic [3:0]     sq_ng_r  [SQS];
  logic           sq_dg_r  [SQS];

  for (genvar g = 0; g < SQS; g++) begin : g_sqrt
    localparam logic [SQW:0] BIT = (SQW+1)'(1) << (2 * (SQS - 1 - g));
    logic [SQW-1:0] n_in, res_in, n_nxt, res_nxt;
    logic [SQW:0]   trial;
    logic [NW-1:0]  a_in [4];
    logic [3:0]     ng_in;
    logic           dg_in;

    if (g == 0) begin : g_first
      assign n_in   = sum9_r;
      assign res_in = '0;
      assign a_in   = a9_r;
      assign ng_in  = ng9_r;
      assign dg_in  = dg9_r;
    end else begin : g_next
      assign n_in   = sq_n_r[g-1];
      assign res_in = sq_res_r[g-1];
      assign a_in   = sq_a_r[g-1];
      assign ng_in  = sq_ng_r[g-1];
      assign dg_in  = sq_dg_r[g-1];
    end

    // try the next root bit, keep it where the remainder allows
    always_comb begin
      trial = (SQW+1)'(res_in) + BIT;
      if ((SQW+1)'(n_in) >= trial) begin
        n_nxt   = SQW'((SQW+1)'(n_in) - trial);
        res_nxt = SQW'((SQW+1)'(res_in >> 1) + BIT);
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[SQ0+g]) begin
        sq_n_r[g]   <= n_nxt;
        sq_res_r[g] <= res_nxt;
        sq_a_r[g]   <= a_in;
        sq_ng_r[g]  <= ng_in;
        sq_dg_r[g]  <= dg_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divide each magnitude by the norm: one quotient bit per stage, four lanes
  // --------------------------------------------------------------------------
  logic [MAGW-1:0] dv_mag_r [QW];
  logic [MAGW-1:0] dv_rem_r [QW][4];
  logic [QW-1:0]   dv_q_r   [QW][4];
  logic [3:0]      dv_ng_r  [QW];
  logic            dv_dg_r  [QW];

  for (genvar d = 0; d < QW; d++) begin : g_div
    logic [MAGW-1:0] mag_in;
    logic [RW-1:0]   rin  [4];
    logic [QW-1:0]   q_in [4];
    logic [MAGW-1:0] rem_nxt [4];
    logic [QW-1:0]   q_nxt   [4];
    logic [3:0]      ge;
    logic [3:0]      ng_in;
    logic            dg_in;

    if (d == 0) begin : g_first
      assign mag_in = sq_res_r[SQS-1][MAGW-1:0];
      assign ng_in  = sq_ng_r[SQS-1];
      assign dg_in  = sq_dg_r[SQS-1];
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rin[l]  = RW'(sq_a_r[SQS-1][l]);
        assign q_in[l] = '0;
      end
    end else begin : g_next
      assign mag_in = dv_mag_r[d-1];
      assign ng_in  = dv_ng_r[d-1];
      assign dg_in  = dv_dg_r[d-1];
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rin[l]  = {dv_rem_r[d-1][l], 1'b0};
        assign q_in[l] = dv_q_r[d-1][l];
      end
    end

    // subtract the norm where it fits and shift in the quotient bit
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        ge[l]      = (rin[l] >= RW'(mag_in));
        rem_nxt[l] = ge[l] ? MAGW'(rin[l] - RW'(mag_in)) : MAGW'(rin[l]);
        q_nxt[l]   = {q_in[l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (en[DV0+d]) begin
        dv_mag_r[d] <= mag_in;
        dv_rem_r[d] <= rem_nxt;
        dv_q_r[d]   <= q_nxt;
        dv_ng_r[d]  <= ng_in;
        dv_dg_r[d]  <= dg_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: round, restore sign, saturate, substitute identity
  // --------------------------------------------------------------------------
  logic                 rnd  [4];
  logic [QW:0]          qr   [4];
  logic signed [EW-1:0] sv   [4];
  logic signed [DW-1:0] qo_nxt [4];
  logic signed [DW-1:0] qo_r   [4];
  logic                 dgo_r;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rnd[l] = ({dv_rem_r[QW-1][l], 1'b0} >= (MAGW+1)'(dv_mag_r[QW-1]));
      qr[l]  = (QW+1)'(dv_q_r[QW-1][l]) + (QW+1)'(rnd[l]);
      sv[l]  = dv_ng_r[QW-1][l] ? -$signed(EW'(qr[l])) : $signed(EW'(qr[l]));
      if (sv[l] > SAT_HI) begin
        qo_nxt[l] = DW'(SAT_HI);
      end else if (sv[l] < SAT_LO) begin
        qo_nxt[l] = DW'(SAT_LO);
      end else begin
        qo_nxt[l] = DW'(sv[l]);
      end
    end
    if (dv_dg_r[QW-1]) begin
      qo_nxt[0] = '0;
      qo_nxt[1] = '0;
      qo_nxt[2] = '0;
      qo_nxt[3] = ONE_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      qo_r  <= qo_nxt;
      dgo_r <= dv_dg_r[QW-1];
    end
  end

  assign out_quat_x     = qo_r[0];
  assign out_quat_y     = qo_r[1];
  assign out_quat_z     = qo_r[2];
  assign out_quat_w     = qo_r[3];
  assign out_degenerate = dgo_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DV0-1] && !sq_dg_r[SQS-1] |-> sq_res_r[SQS-1] >= MAG_MIN)
    else $error("norm below the normalized range");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_quat_x == 0 && out_quat_y == 0 && out_quat_z == 0 && out_quat_w == ONE_SAT)
    else $error("degenerate result is not the identity");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_quat_x <= ONE_SAT && out_quat_x >= -ONE_SAT &&
      out_quat_w <= ONE_SAT && out_quat_w >= -ONE_SAT)
    else $error("component exceeds unit magnitude");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the frame-to-quaternion converter against an in-bench predictor:
// directed frames, then random frames, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int FB         = fq_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM   = 1830;
  localparam int STALL_LIM  = 4000;
  localparam int LATENCY    = FB + 43;

  typedef struct packed {
    logic signed [15:0] fx, fy, fz, ux, uy, uz;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] qx, qy, qz, qw;
    logic               degen;
  } quat_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] in_fwd_x, in_fwd_y, in_fwd_z, in_up_x, in_up_y, in_up_z;
  logic signed [15:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;
  logic out_degenerate;
  logic in_ready_seen;

  frame_t frame_q[$];
  quat_t  quat_q[$];
  int     n_err;
  int     idle_cycles;
  int     hold_left;
  int     out_count;
  bit     gen_done;
  bit     calm;
  bit     hold_taken;

  frame_to_quaternion_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_fwd_x(in_fwd_x), .in_fwd_y(in_fwd_y), .in_fwd_z(in_fwd_z),
    .in_up_x(in_up_x), .in_up_y(in_up_y), .in_up_z(in_up_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_degenerate(out_degenerate)
  );

  // Round half up of v / 2^FB
  function automatic longint rnd_shift(longint v);
    longint b;
    b = v + (longint'(1) << (FB - 1));
    return b >>> FB;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // Build the frame, pick the trace branch and normalise
  function automatic quat_t frame_quat(frame_t f);
    longint fx, fy, fz, ux, uy, uz, lx, ly, lz, vx, vy, vz, tr, s, one;
    longint p[4];
    longint unsigned a[4];
    longint unsigned mx, sum, mag, q;
    longint v;
    quat_t r;
    fx = f.fx; fy = f.fy; fz = f.fz; ux = f.ux; uy = f.uy; uz = f.uz;
    one = longint'(1) << FB;
    lx = rnd_shift(uy * fz - uz * fy);
    ly = rnd_shift(uz * fx - ux * fz);
    lz = rnd_shift(ux * fy - uy * fx);
    vx = rnd_shift(fy * lz - fz * ly);
    vy = rnd_shift(fz * lx - fx * lz);
    vz = rnd_shift(fx * ly - fy * lx);
    tr = lx + vy + fz;
    if (tr > 0) begin
      s = one + tr;
      p[0] = vz - fy; p[1] = fx - lz; p[2] = ly - vx; p[3] = s;
    end else if (lx >= vy && lx >= fz) begin
      s = one + lx - vy - fz;
      p[0] = s; p[1] = ly + vx; p[2] = lz + fx; p[3] = vz - fy;
    end else if (vy > fz) begin
      s = one + vy - lx - fz;
      p[0] = vx + ly; p[1] = s; p[2] = fy + vz; p[3] = fx - lz;
    end else begin
      s = one + fz - lx - vy;
      p[0] = fx + lz; p[1] = fy + vz; p[2] = s; p[3] = ly - vx;
    end
    if (s <= 0) begin
      r = '0;
      r.qw = 16'(sat16(one));
      r.degen = 1'b1;
      return r;
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = p[i] < 0 ? longint'(-p[i]) : p[i];
      if (a[i] > mx) mx = a[i];
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 4; i++) a[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 4; i++) a[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += a[i] * a[i];
    mag = floor_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = ((a[i] << FB) * 2 + mag) / (2 * mag);
      v = q;
      if (p[i] < 0) v = -v;
      case (i)
        0: r.qx = 16'(sat16(v));
        1: r.qy = 16'(sat16(v));
        2: r.qz = 16'(sat16(v));
        default: r.qw = 16'(sat16(v));
      endcase
    end
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %0s at result %0d: got %0d want %0d", what, out_count, got, want);
    n_err++;
  endtask

  task automatic add_frame(logic signed [15:0] fx, fy, fz, ux, uy, uz);
    frame_t f;
    f = {fx, fy, fz, ux, uy, uz};
    frame_q.push_back(f);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 32768)) - 16384);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'(int'($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stimulus: directed frames, then random ones
  initial begin
    logic signed [15:0] c[6];
    rst_n = 1'b0;
    gen_done = 1'b0;
    add_frame(16384, 0, 0, 0, 0, 16384);
    add_frame(0, 16384, 0, 0, 0, 16384);
    add_frame(0, 0, 16384, 0, 16384, 0);
    add_frame(0, 0, -16384, 0, -16384, 0);
    add_frame(-16384, 0, 0, 0, -16384, 0);
    add_frame(0, -16384, 0, 16384, 0, 0);
    add_frame(0, 0, 0, 0, 0, 0);
    add_frame(16384, 0, 0, 16384, 0, 0);
    add_frame(16384, 16384, 0, -16384, -16384, 0);
    add_frame(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    add_frame(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_frame(16'sh8000, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    add_frame(16'sh7fff, 0, 0, 0, 16'sh7fff, 0);
    add_frame(1, 0, 0, 0, 1, 0);
    add_frame(-1, -1, -1, 1, -1, 1);
    add_frame(11585, 11585, 0, 0, 0, 16384);
    add_frame(0, 0, 16384, 16384, 0, 0);
    add_frame(0, 16384, 0, 0, 0, -16384);
    add_frame(-16384, 0, 0, 0, 0, 16384);
    add_frame(9459, 9459, 9459, -9459, 9459, 0);
    for (int n = 0; n < N_RANDOM; n++) begin
      for (int k = 0; k < 6; k++) c[k] = rand_comp();
      if ($urandom_range(0, 9) == 0) c[3:5] = c[0:2];
      add_frame(c[0], c[1], c[2], c[3], c[4], c[5]);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    gen_done = 1'b1;
  end

  // Driver: offer pending frames, with random gaps except in the calm stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      {in_fwd_x, in_fwd_y, in_fwd_z, in_up_x, in_up_y, in_up_z} <= '0;
    end else if (!in_valid || in_ready_seen) begin
      if (frame_q.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        frame_t f;
        f = frame_q.pop_front();
        quat_q.push_back(frame_quat(f));
        {in_fwd_x, in_fwd_y, in_fwd_z, in_up_x, in_up_y, in_up_z} <= f;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Acceptance as seen at the last rising edge
  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  // Calm stretch for a few hundred frames in the middle of the run
  always @(posedge clk) calm <= (frame_q.size() < 1200 && frame_q.size() > 900);

  // Receiver: random stalls, and one long hold-off that backs up the pipeline
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_taken && frame_q.size() < 1600) begin
      hold_taken <= 1'b1;
      hold_left <= 3 * LATENCY;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(0, 99) >= 16;
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (quat_q.size() == 0) begin
        $display("unexpected result %0d", out_count);
        n_err++;
      end else begin
        quat_t w;
        w = quat_q.pop_front();
        if (out_quat_x !== w.qx) report("quat_x", out_quat_x, w.qx);
        if (out_quat_y !== w.qy) report("quat_y", out_quat_y, w.qy);
        if (out_quat_z !== w.qz) report("quat_z", out_quat_z, w.qz);
        if (out_quat_w !== w.qw) report("quat_w", out_quat_w, w.qw);
        if (out_degenerate !== w.degen) report("degenerate", out_degenerate, w.degen);
      end
      out_count <= out_count + 1;
    end
  end

  // Watchdog and end of run
  initial begin
    n_err = 0;
    out_count = 0;
    idle_cycles = 0;
    wait (gen_done);
    while (frame_q.size() > 0 || quat_q.size() > 0 || in_valid) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIM) begin
        $display("FAIL");
        $finish;
      end
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
